// ===== hdl/kdm_pkg.sv =====
// Shared types, constants and table builder for the kiwi drive mixer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package kdm_pkg;

  // Angle and field widths
  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = ANGLE_BITS - 2;
  localparam int QN         = 1 << FRAC_BITS;
  localparam int MODE_W     = 2;
  localparam int HEAD_W     = 12;
  localparam int CMD_W      = 8;
  localparam int DZ_W       = 7;

  // Datapath widths
  localparam int COS_W   = 15;               // table entry, 0..16384
  localparam int TRIG_W  = COS_W + 1;        // signed cos / sin, Q1.14
  localparam int MAG_W   = CMD_W;            // magnitude up to 128
  localparam int SUM_W   = MAG_W + 1;        // |speed| + |rotation|
  localparam int SQ_W    = 2 * MAG_W - 1;    // square, up to 16384
  localparam int QUO_W   = MAG_W;            // rescaled magnitude
  localparam int SGN_W   = QUO_W + 1;        // rescaled signed value
  localparam int TRY_W   = SUM_W + QUO_W - 1;
  localparam int Q_SH    = 14;
  localparam int PROD_W  = TRIG_W + Q_SH;    // constant times cos / sin
  localparam int COEF_W  = PROD_W + 1;       // Q28 wheel cosine
  localparam int MUL_W   = SGN_W + COEF_W;   // speed times Q28 cosine
  localparam int WH_W    = 10;               // wheel value before rotation
  localparam int ACC_W   = 12;               // boosted wheel plus rotation

  // Divider layout
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  // Stage numbering
  localparam int ST_FRONT = 0;
  localparam int ST_DIV0  = 1;
  localparam int ST_SEL   = ST_DIV0 + DIV_STAGES;
  localparam int ST_PART  = ST_SEL + 1;
  localparam int ST_COEF  = ST_PART + 1;
  localparam int ST_MUL   = ST_COEF + 1;
  localparam int ST_SCALE = ST_MUL + 1;
  localparam int ST_OUT   = ST_SCALE + 1;
  localparam int NSTG     = ST_OUT + 1;

  // Mixing constants
  localparam int FULL_SCALE = 127;
  localparam int BOOST_TAIL = 40;
  localparam int BOOST_SIDE = 100;
  localparam logic signed [TRIG_W-1:0] HALF_Q14       = 16'sd8192;
  localparam logic signed [TRIG_W-1:0] ROOT3_HALF_Q14 = 16'sd14189;
  localparam logic [DZ_W-1:0] DZ_RESET = 7'd10;

  // Taylor coefficients of cos(pi/2 t), Q30
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint COEF2   = 64'sd1324675878;
  localparam longint COEF4   = 64'sd272375552;
  localparam longint COEF6   = 64'sd22401992;
  localparam longint COEF8   = 64'sd987047;

  typedef enum logic [MODE_W-1:0] {
    MODE_JOY   = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2,
    MODE_BOTH  = 2'd3
  } mode_t;

  typedef logic [COS_W-1:0] qcos_tab_t [QN+1];

  typedef struct packed {
    logic [1:0]       quad;
    logic [COS_W-1:0] x;
    logic [COS_W-1:0] y;
    logic             spd_neg;
    logic             rot_neg;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0]  rem_s;
    logic [SQ_W-1:0]  rem_r;
    logic [QUO_W-1:0] q_s;
    logic [QUO_W-1:0] q_r;
    logic [SUM_W-1:0] d;
    side_t            side;
  } divst_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

  function automatic logic [COS_W-1:0] quarter_cos(input int f);
    longint t;
    longint u;
    longint r;
    t = longint'(f) << (32 - ANGLE_BITS);
    u = (t * t) >>> 30;
    r = COEF8;
    r = COEF6 - ((r * u) >>> 30);
    r = COEF4 - ((r * u) >>> 30);
    r = COEF2 - ((r * u) >>> 30);
    r = Q30_ONE - ((r * u) >>> 30);
    if (r < 0) r = 0;
    r = (r + (longint'(1) << 15)) >>> 16;
    if (r > 16384) r = 16384;
    return r[COS_W-1:0];
  endfunction

  function automatic qcos_tab_t build_qcos();
    qcos_tab_t tab;
    for (int i = 0; i <= QN; i++) begin
      tab[i] = quarter_cos(i);
    end
    return tab;
  endfunction

  function automatic logic signed [CMD_W-1:0] sat_drive(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] lim;
    lim = ACC_W'(FULL_SCALE);
    if (v > lim) return CMD_W'(FULL_SCALE);
    else if (v < -lim) return CMD_W'(-FULL_SCALE);
    else return v[CMD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/kdm_in_if.sv =====
// Request channel of the kiwi drive mixer: one drive command per request.
// Depends on kdm_pkg for field widths.
`default_nettype none
interface kdm_in_if;
  logic                               valid;
  logic                               ready;
  logic [kdm_pkg::MODE_W-1:0]         mode;
  logic [kdm_pkg::HEAD_W-1:0]         heading;
  logic signed [kdm_pkg::CMD_W-1:0]   speed;
  logic signed [kdm_pkg::CMD_W-1:0]   turn_stick;

  modport source (output valid, mode, heading, speed, turn_stick, input ready);
  modport sink   (input valid, mode, heading, speed, turn_stick, output ready);
endinterface
`default_nettype wire

// ===== hdl/kdm_out_if.sv =====
// Result channel of the kiwi drive mixer: three saturated wheel commands.
// Depends on kdm_pkg for field widths.
`default_nettype none
interface kdm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [kdm_pkg::CMD_W-1:0]   right_drive;
  logic signed [kdm_pkg::CMD_W-1:0]   left_drive;
  logic signed [kdm_pkg::CMD_W-1:0]   tail_drive;

  modport source (output valid, right_drive, left_drive, tail_drive, input ready);
  modport sink   (input valid, right_drive, left_drive, tail_drive, output ready);
endinterface
`default_nettype wire

// ===== hdl/kdm_cfg_if.sv =====
// Configuration write channel of the kiwi drive mixer: turn deadzone only.
// Depends on kdm_pkg for the register width.
`default_nettype none
interface kdm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kdm_pkg::DZ_W-1:0]   turn_deadzone;

  modport source (output valid, turn_deadzone, input ready);
  modport sink   (input valid, turn_deadzone, output ready);
endinterface
`default_nettype wire

// ===== hdl/kdm_ctl.sv =====
// Pipeline occupancy and per-stage load enables for the mixer.
// Depends on kdm_pkg (stage count, pipe_ctl_t).
`default_nettype none
module kdm_ctl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               out_ready,
  output kdm_pkg::pipe_ctl_t      ctl
);

  localparam int L = kdm_pkg::NSTG - 1;

  logic [kdm_pkg::NSTG-1:0] vld_r;
  logic [kdm_pkg::NSTG-1:0] vld_nxt;
  logic [kdm_pkg::NSTG-1:0] en;

  // A stage loads when some stage at or after it has room, or the output drains
  always_comb begin
    logic [kdm_pkg::NSTG-1:0] low_mask;
    for (int k = 0; k < kdm_pkg::NSTG; k++) begin
      low_mask = (kdm_pkg::NSTG'(1) << k) - kdm_pkg::NSTG'(1);
      en[k]    = out_ready | ~(&(vld_r | low_mask));
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < kdm_pkg::NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = vld_r;

  // Requests in minus results out equals change in occupancy
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_nxt) + int'(vld_r[L] && out_ready)
      == $countones(vld_r) + int'(in_valid && en[0]))
    else $error("pipeline occupancy lost or gained an item");

  // Input back-pressure only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en[0] |-> (&vld_r && !out_ready))
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

// ===== hdl/kdm_front.sv =====
// Front stage: mode select, deadzone, magnitudes, squares and cosine table read.
// Depends on kdm_pkg (types, quarter-wave cosine table builder).
`default_nettype none
module kdm_front (
  input  wire logic                             clk,
  input  wire kdm_pkg::pipe_ctl_t               ctl,
  input  wire logic [kdm_pkg::DZ_W-1:0]         turn_deadzone,
  input  wire logic [kdm_pkg::MODE_W-1:0]       mode,
  input  wire logic [kdm_pkg::HEAD_W-1:0]       heading,
  input  wire logic signed [kdm_pkg::CMD_W-1:0] speed,
  input  wire logic signed [kdm_pkg::CMD_W-1:0] turn_stick,
  output kdm_pkg::divst_t                       s1
);

  localparam int AB = kdm_pkg::ANGLE_BITS;
  localparam int FB = kdm_pkg::FRAC_BITS;
  localparam kdm_pkg::qcos_tab_t QCOS = kdm_pkg::build_qcos();

  kdm_pkg::mode_t                     mode_c;
  logic [AB-1:0]                      ang;
  logic signed [kdm_pkg::CMD_W-1:0]   spd;
  logic signed [kdm_pkg::CMD_W:0]     spd_wide;
  logic signed [kdm_pkg::CMD_W:0]     spd_abs_w;
  logic signed [kdm_pkg::CMD_W:0]     rot_wide;
  logic signed [kdm_pkg::CMD_W:0]     rot_abs_w;
  logic [kdm_pkg::MAG_W-1:0]          spd_abs;
  logic [kdm_pkg::MAG_W-1:0]          rot_mag;
  logic [kdm_pkg::MAG_W-1:0]          rot_abs;
  logic                               rot_live;
  logic [kdm_pkg::SUM_W-1:0]          mag;
  logic [2*kdm_pkg::MAG_W-1:0]        spd_sq;
  logic [2*kdm_pkg::MAG_W-1:0]        rot_sq;
  logic [FB:0]                        x_addr;
  logic [FB:0]                        y_addr;

  kdm_pkg::divst_t s1_r;

  assign mode_c = kdm_pkg::mode_t'(mode);

  // Strafe modes override heading and speed; both buttons behave as strafe left
  always_comb begin
    unique case (mode_c)
      kdm_pkg::MODE_JOY: begin
        ang = heading[AB-1:0];
        spd = speed;
      end
      kdm_pkg::MODE_LEFT, kdm_pkg::MODE_BOTH: begin
        ang = {1'b1, {(AB-1){1'b0}}};
        spd = kdm_pkg::CMD_W'(kdm_pkg::FULL_SCALE);
      end
      kdm_pkg::MODE_RIGHT: begin
        ang = '0;
        spd = kdm_pkg::CMD_W'(kdm_pkg::FULL_SCALE);
      end
    endcase
  end

  always_comb begin
    spd_wide  = (kdm_pkg::CMD_W+1)'(spd);
    spd_abs_w = (spd_wide < 0) ? -spd_wide : spd_wide;
    spd_abs   = spd_abs_w[kdm_pkg::MAG_W-1:0];
    rot_wide  = -((kdm_pkg::CMD_W+1)'(turn_stick));
    rot_abs_w = (rot_wide < 0) ? -rot_wide : rot_wide;
    rot_mag   = rot_abs_w[kdm_pkg::MAG_W-1:0];
    rot_live  = rot_mag >= kdm_pkg::MAG_W'(turn_deadzone);
    rot_abs   = rot_live ? rot_mag : '0;
    mag       = kdm_pkg::SUM_W'(spd_abs) + kdm_pkg::SUM_W'(rot_abs);
    spd_sq    = spd_abs * spd_abs;
    rot_sq    = rot_abs * rot_abs;
    x_addr    = {1'b0, ang[FB-1:0]};
    y_addr    = (FB+1)'(kdm_pkg::QN) - {1'b0, ang[FB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[kdm_pkg::ST_FRONT]) begin
      s1_r.rem_s        <= spd_sq[kdm_pkg::SQ_W-1:0];
      s1_r.rem_r        <= rot_sq[kdm_pkg::SQ_W-1:0];
      s1_r.q_s          <= '0;
      s1_r.q_r          <= '0;
      // zero magnitude: divide zero by one so both stay zero
      s1_r.d            <= (mag == '0) ? kdm_pkg::SUM_W'(1) : mag;
      s1_r.side.quad    <= ang[AB-1:AB-2];
      s1_r.side.x       <= QCOS[x_addr];
      s1_r.side.y       <= QCOS[y_addr];
      s1_r.side.spd_neg <= spd < 0;
      s1_r.side.rot_neg <= rot_live && (rot_wide < 0);
    end
  end

  assign s1 = s1_r;

endmodule
`default_nettype wire

// ===== hdl/kdm_div.sv =====
// Pipelined restoring divider: speed and rotation squares over total magnitude.
// Depends on kdm_pkg (divst_t, stage numbering).
`default_nettype none
module kdm_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kdm_pkg::pipe_ctl_t ctl,
  input  wire kdm_pkg::divst_t    s_in,
  output kdm_pkg::divst_t         s_out
);

  localparam int NS   = kdm_pkg::DIV_STAGES;
  localparam int LAST = kdm_pkg::ST_DIV0 + NS - 1;

  kdm_pkg::divst_t src    [NS];
  kdm_pkg::divst_t st_nxt [NS];
  kdm_pkg::divst_t st_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int HI = kdm_pkg::QUO_W - 1 - k * kdm_pkg::DIV_BITS;

    if (k == 0) begin : g_head
      assign src[k] = s_in;
    end else begin : g_tail
      assign src[k] = st_r[k-1];
    end

    // Two quotient bits per stage, most significant first
    always_comb begin
      logic [kdm_pkg::TRY_W-1:0] trial;
      st_nxt[k] = src[k];
      for (int b = 0; b < kdm_pkg::DIV_BITS; b++) begin
        trial = kdm_pkg::TRY_W'(src[k].d) << (HI - b);
        if (kdm_pkg::TRY_W'(st_nxt[k].rem_s) >= trial) begin
          st_nxt[k].rem_s     = st_nxt[k].rem_s - trial[kdm_pkg::SQ_W-1:0];
          st_nxt[k].q_s[HI-b] = 1'b1;
        end
        if (kdm_pkg::TRY_W'(st_nxt[k].rem_r) >= trial) begin
          st_nxt[k].rem_r     = st_nxt[k].rem_r - trial[kdm_pkg::SQ_W-1:0];
          st_nxt[k].q_r[HI-b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en[kdm_pkg::ST_DIV0 + k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign s_out = st_r[NS-1];

  // Remainders end below the divisor
  a_rem_s: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld[LAST] |-> (st_r[NS-1].rem_s < kdm_pkg::SQ_W'(st_r[NS-1].d)))
    else $error("speed remainder not below divisor");

  a_rem_r: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld[LAST] |-> (st_r[NS-1].rem_r < kdm_pkg::SQ_W'(st_r[NS-1].d)))
    else $error("rotation remainder not below divisor");

endmodule
`default_nettype wire

// ===== hdl/kdm_wheel.sv =====
// Wheel stages: cos/sin select, mount-angle mixing, scaling, boost and saturation.
// Depends on kdm_pkg (types, constants, sat_drive).
`default_nettype none
module kdm_wheel (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire kdm_pkg::pipe_ctl_t        ctl,
  input  wire kdm_pkg::divst_t           q_in,
  output logic signed [kdm_pkg::CMD_W-1:0] right_drive,
  output logic signed [kdm_pkg::CMD_W-1:0] left_drive,
  output logic signed [kdm_pkg::CMD_W-1:0] tail_drive
);

  localparam int SG = kdm_pkg::SGN_W;
  localparam int TW = kdm_pkg::TRIG_W;
  localparam int PW = kdm_pkg::PROD_W;
  localparam int CW = kdm_pkg::COEF_W;
  localparam int MW = kdm_pkg::MUL_W;
  localparam int WW = kdm_pkg::WH_W;
  localparam int AW = kdm_pkg::ACC_W;
  localparam logic signed [MW-1:0] RND_HI = (MW'(1) << (2 * kdm_pkg::Q_SH)) - MW'(1);
  localparam logic signed [MW-1:0] RND_LO = (MW'(1) << kdm_pkg::Q_SH) - MW'(1);

  // select stage
  logic signed [SG-1:0] spd6_r, rot6_r, spd6_nxt, rot6_nxt;
  logic signed [TW-1:0] c6_r, s6_r, c6_nxt, s6_nxt;
  logic signed [TW-1:0] xs, ys;
  // part products
  logic signed [SG-1:0] spd7_r, rot7_r;
  logic signed [TW-1:0] c7_r;
  logic signed [PW-1:0] pc7_r, ps7_r;
  // wheel cosines, Q28
  logic signed [SG-1:0] spd8_r, rot8_r;
  logic signed [TW-1:0] c8_r;
  logic signed [CW-1:0] rc8_r, lc8_r;
  // wheel products
  logic signed [SG-1:0] rot9_r;
  logic signed [MW-1:0] mr9_r, ml9_r, mt9_r;
  // scaled wheel values
  logic signed [SG-1:0] rot10_r;
  logic signed [WW-1:0] rs10_r, ls10_r, ts10_r;
  logic signed [MW-1:0] mr_adj, ml_adj, mt_adj;
  // boost and sum
  logic [WW-1:0]        abs_rs, abs_ls, abs_ts, abs_max;
  logic                 boost;
  logic signed [AW-1:0] diff, rs_e, ls_e, rb, lb, rsum, lsum, tsum;
  logic signed [kdm_pkg::CMD_W-1:0] right_r, left_r, tail_r;

  always_comb begin
    spd6_nxt = q_in.side.spd_neg ? -$signed({1'b0, q_in.q_s}) : $signed({1'b0, q_in.q_s});
    rot6_nxt = q_in.side.rot_neg ? -$signed({1'b0, q_in.q_r}) : $signed({1'b0, q_in.q_r});
    xs = $signed({1'b0, q_in.side.x});
    ys = $signed({1'b0, q_in.side.y});
    unique case (q_in.side.quad)
      2'd0: begin c6_nxt = xs;  s6_nxt = ys;  end
      2'd1: begin c6_nxt = -ys; s6_nxt = xs;  end
      2'd2: begin c6_nxt = -xs; s6_nxt = -ys; end
      2'd3: begin c6_nxt = ys;  s6_nxt = -xs; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en[kdm_pkg::ST_SEL]) begin
      spd6_r <= spd6_nxt;
      rot6_r <= rot6_nxt;
      c6_r   <= c6_nxt;
      s6_r   <= s6_nxt;
    end
    if (ctl.en[kdm_pkg::ST_PART]) begin
      spd7_r <= spd6_r;
      rot7_r <= rot6_r;
      c7_r   <= c6_r;
      pc7_r  <= -(PW'(c6_r) * PW'(kdm_pkg::HALF_Q14));
      ps7_r  <= PW'(s6_r) * PW'(kdm_pkg::ROOT3_HALF_Q14);
    end
    if (ctl.en[kdm_pkg::ST_COEF]) begin
      spd8_r <= spd7_r;
      rot8_r <= rot7_r;
      c8_r   <= c7_r;
      rc8_r  <= CW'(pc7_r) + CW'(ps7_r);
      lc8_r  <= CW'(pc7_r) - CW'(ps7_r);
    end
    if (ctl.en[kdm_pkg::ST_MUL]) begin
      rot9_r <= rot8_r;
      mr9_r  <= MW'(spd8_r) * MW'(rc8_r);
      ml9_r  <= MW'(spd8_r) * MW'(lc8_r);
      mt9_r  <= MW'(spd8_r) * MW'(c8_r);
    end
  end

  // Truncate toward zero: bias negative values before the arithmetic shift
  always_comb begin
    mr_adj = mr9_r + (mr9_r[MW-1] ? RND_HI : '0);
    ml_adj = ml9_r + (ml9_r[MW-1] ? RND_HI : '0);
    mt_adj = mt9_r + (mt9_r[MW-1] ? RND_LO : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[kdm_pkg::ST_SCALE]) begin
      rot10_r <= rot9_r;
      rs10_r  <= WW'(mr_adj >>> (2 * kdm_pkg::Q_SH));
      ls10_r  <= WW'(ml_adj >>> (2 * kdm_pkg::Q_SH));
      ts10_r  <= WW'(mt_adj >>> kdm_pkg::Q_SH);
    end
  end

  // Push the side wheels out to full scale when the tail is nearly idle and a side wheel exceeds BOOST_SIDE
  always_comb begin
    abs_rs  = WW'((rs10_r < 0) ? -rs10_r : rs10_r);
    abs_ls  = WW'((ls10_r < 0) ? -ls10_r : ls10_r);
    abs_ts  = WW'((ts10_r < 0) ? -ts10_r : ts10_r);
    abs_max = (abs_rs > abs_ls) ? abs_rs : abs_ls;
    boost   = (abs_ts < WW'(kdm_pkg::BOOST_TAIL))
              && ((abs_rs > WW'(kdm_pkg::BOOST_SIDE)) || (abs_ls > WW'(kdm_pkg::BOOST_SIDE)));
    diff    = AW'(kdm_pkg::FULL_SCALE) - $signed({2'b00, abs_max});
    rs_e    = AW'(rs10_r);
    ls_e    = AW'(ls10_r);
    rb      = boost ? ((rs10_r > 0) ? rs_e + diff : rs_e - diff) : rs_e;
    lb      = boost ? ((ls10_r > 0) ? ls_e + diff : ls_e - diff) : ls_e;
    rsum    = rb + AW'(rot10_r);
    lsum    = lb + AW'(rot10_r);
    tsum    = AW'(ts10_r) + AW'(rot10_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[kdm_pkg::ST_OUT]) begin
      right_r <= kdm_pkg::sat_drive(rsum);
      left_r  <= kdm_pkg::sat_drive(lsum);
      tail_r  <= kdm_pkg::sat_drive(tsum);
    end
  end

  assign right_drive = right_r;
  assign left_drive  = left_r;
  assign tail_drive  = tail_r;

  // Saturation never lets the most negative code through
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld[kdm_pkg::ST_OUT] |->
      (right_r != -kdm_pkg::CMD_W'(128) && left_r != -kdm_pkg::CMD_W'(128)
       && tail_r != -kdm_pkg::CMD_W'(128)))
    else $error("wheel command outside the saturated range");

endmodule
`default_nettype wire

// ===== hdl/kiwi_drive_motor_mixer_unit.sv =====
// Top level of the kiwi drive mixer: deadzone register, pipeline control, datapath.
// Depends on kdm_pkg, the three channel interfaces and the kdm_* modules.
//
// Usage
//   in_req  : one drive command per request (mode, heading, speed, turn_stick).
//   out_res : one result per request, right/left/tail wheel commands in -127..127.
//   cfg_wr  : writes turn_deadzone; always ready, write only while the block is idle.
// Timing
//   Eleven register stages: front (mode, deadzone, squares, cosine table read),
//   four divider stages at two quotient bits each, then select, part products,
//   wheel cosines, wheel multiply, scaling and boost/saturate in the output register.
//   One request per cycle is accepted while the output is taken each cycle.
// Stalls
//   Each stage holds while it and every stage after it are full and out_res is stalled;
//   empty stages keep filling, so in_req still accepts until the pipe is full.
// Reset
//   rst_n empties the pipeline and sets turn_deadzone to 10. The cosine table
//   is constant and needs no setup.
`default_nettype none
module kiwi_drive_motor_mixer_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  kdm_in_if.sink      in_req,
  kdm_out_if.source   out_res,
  kdm_cfg_if.sink     cfg_wr
);

  logic [kdm_pkg::DZ_W-1:0] turn_deadzone_r;
  kdm_pkg::pipe_ctl_t       ctl;
  kdm_pkg::divst_t          s1;
  kdm_pkg::divst_t          s_div;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_deadzone_r <= kdm_pkg::DZ_RESET;
    end else if (cfg_wr.valid) begin
      turn_deadzone_r <= cfg_wr.turn_deadzone;
    end
  end

  kdm_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .out_ready (out_res.ready),
    .ctl       (ctl)
  );

  assign in_req.ready  = ctl.en[kdm_pkg::ST_FRONT];
  assign out_res.valid = ctl.vld[kdm_pkg::ST_OUT];

  kdm_front u_front (
    .clk           (clk),
    .ctl           (ctl),
    .turn_deadzone (turn_deadzone_r),
    .mode          (in_req.mode),
    .heading       (in_req.heading),
    .speed         (in_req.speed),
    .turn_stick    (in_req.turn_stick),
    .s1            (s1)
  );

  kdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .s_in  (s1),
    .s_out (s_div)
  );

  kdm_wheel u_wheel (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .q_in        (s_div),
    .right_drive (out_res.right_drive),
    .left_drive  (out_res.left_drive),
    .tail_drive  (out_res.tail_drive)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for kiwi_drive_motor_mixer_unit: directed corners, deadzone limits,
// random drive commands under random idling and a long output hold-off.
// Depends on kdm_pkg and the kdm_in_if, kdm_out_if and kdm_cfg_if channel interfaces.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  QUARTER       = 1024;        // table steps per quarter turn
  localparam int  HALF_TURN     = 2048;
  localparam int  DRIVE_MAX     = 127;
  localparam int  TAIL_LOW      = 40;
  localparam int  SIDE_HIGH     = 100;
  localparam int  DZ_AFTER_RST  = 10;
  localparam int  WATCHDOG_MAX  = 2000;
  localparam int  HOLD_CYCLES   = 120;
  localparam int  SETTLE_CYCLES = 30;
  localparam int  MAX_PRINTS    = 40;
  localparam longint SIN60_Q14  = 14189;
  localparam longint HALF_Q14V  = 8192;
  localparam longint ONE_Q30    = 1073741824;
  localparam longint TAY2       = 1324675878;
  localparam longint TAY4       = 272375552;
  localparam longint TAY6       = 22401992;
  localparam longint TAY8       = 987047;

  typedef struct {
    kdm_pkg::mode_t     mode;
    logic [11:0]        heading;
    logic signed [7:0]  speed;
    logic signed [7:0]  turn_stick;
  } drive_cmd_t;

  typedef struct {
    logic signed [7:0]  right;
    logic signed [7:0]  left;
    logic signed [7:0]  tail;
    bit                 boosted;
  } wheel_set_t;

  logic clk = 1'b0;
  logic rst_n;

  kdm_in_if  in_ch ();
  kdm_out_if out_ch ();
  kdm_cfg_if cfg_ch ();

  kiwi_drive_motor_mixer_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch),
    .cfg_wr  (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int          cos_lut [QUARTER+1];
  wheel_set_t  wheels_due [$];
  logic [6:0]  dz_shadow;
  int          mismatches = 0;
  int          n_cmds = 0;
  int          n_results = 0;
  int          n_cfg = 0;
  int          n_boost = 0;
  int          quiet_cycles = 0;
  bit          tx_idling = 1'b0;
  bit          rx_idling = 1'b0;
  int          hold_requests = 0;
  int          hold_served = 0;

  // Q1.14 cosine of a quarter-turn fraction, Taylor polynomial in Horner form
  function automatic int taylor_cos_q14(int f);
    longint t;
    longint u;
    longint acc;
    t = longint'(f) << 20;
    u = (t * t) >>> 30;
    acc = TAY8;
    acc = TAY6 - ((acc * u) >>> 30);
    acc = TAY4 - ((acc * u) >>> 30);
    acc = TAY2 - ((acc * u) >>> 30);
    acc = ONE_Q30 - ((acc * u) >>> 30);
    if (acc < 0) acc = 0;
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) acc = 16384;
    return int'(acc);
  endfunction

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [7:0] clamp_drive(longint v);
    if (v > DRIVE_MAX) v = DRIVE_MAX;
    if (v < -DRIVE_MAX) v = -DRIVE_MAX;
    return 8'(v);
  endfunction

  function automatic wheel_set_t mix_wheels(drive_cmd_t cmd, logic [6:0] dz);
    wheel_set_t w;
    int         ang;
    int         frac;
    longint     spd, rot, tot, c, s, x, y, rs, ls, ts, diff, dzl;
    ang = cmd.heading;
    spd = cmd.speed;
    rot = cmd.turn_stick;
    rot = -rot;
    dzl = dz;
    case (cmd.mode)
      kdm_pkg::MODE_LEFT, kdm_pkg::MODE_BOTH: begin
        ang = HALF_TURN;
        spd = DRIVE_MAX;
      end
      kdm_pkg::MODE_RIGHT: begin
        ang = 0;
        spd = DRIVE_MAX;
      end
      default: ;
    endcase
    if (mag_of(rot) < dzl) rot = 0;
    tot = mag_of(spd) + mag_of(rot);
    if (tot != 0) begin
      spd = spd * mag_of(spd) / tot;
      rot = rot * mag_of(rot) / tot;
    end
    frac = ang % QUARTER;
    x = cos_lut[frac];
    y = cos_lut[QUARTER - frac];
    case (ang / QUARTER)
      0:       begin c = x;  s = y;  end
      1:       begin c = -y; s = x;  end
      2:       begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    rs = spd * (-HALF_Q14V * c + SIN60_Q14 * s) / (longint'(1) << 28);
    ls = spd * (-HALF_Q14V * c - SIN60_Q14 * s) / (longint'(1) << 28);
    ts = spd * c / 16384;
    w.boosted = 1'b0;
    // push the side wheels out to full scale when the tail is nearly idle and a side wheel exceeds SIDE_HIGH
    if (mag_of(ts) < TAIL_LOW && (mag_of(rs) > SIDE_HIGH || mag_of(ls) > SIDE_HIGH)) begin
      diff = (mag_of(rs) > mag_of(ls)) ? DRIVE_MAX - mag_of(rs) : DRIVE_MAX - mag_of(ls);
      rs = (rs > 0) ? rs + diff : rs - diff;
      ls = (ls > 0) ? ls + diff : ls - diff;
      w.boosted = 1'b1;
    end
    w.right = clamp_drive(rs + rot);
    w.left  = clamp_drive(ls + rot);
    w.tail  = clamp_drive(ts + rot);
    return w;
  endfunction

  function automatic drive_cmd_t make_cmd(int mode, int heading, int speed, int turn);
    drive_cmd_t cmd;
    cmd.mode       = kdm_pkg::mode_t'(mode[1:0]);
    cmd.heading    = 12'(heading);
    cmd.speed      = 8'(speed);
    cmd.turn_stick = 8'(turn);
    return cmd;
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stick_extreme();
    case ($urandom_range(0, 3))
      0:       return -128;
      1:       return -127;
      2:       return 127;
      default: return 0;
    endcase
  endfunction

  function automatic drive_cmd_t random_cmd();
    int mode, heading, speed, turn;
    mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
    case ($urandom_range(0, 3))
      0:       heading = 1024 + $urandom_range(0, 400) - 200;   // ahead, boost window
      1:       heading = 3072 + $urandom_range(0, 400) - 200;   // behind, boost window
      default: heading = $urandom_range(0, 4095);
    endcase
    speed = ($urandom_range(0, 9) == 0) ? pick_stick_extreme() : $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0:       turn = pick_stick_extreme();
      1:       turn = ($urandom_range(0, 1) ? 1 : -1) * (int'(dz_shadow) + $urandom_range(0, 2) - 1);
      default: turn = $urandom_range(0, 255);
    endcase
    return make_cmd(mode, heading, speed, turn);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic signed [7:0] got, logic signed [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", n_results, name, got, want));
  endtask

  // Channel monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    wheel_set_t want;
    bit         moved;
    moved = 1'b0;
    if (!rst_n) begin
      dz_shadow = 7'(DZ_AFTER_RST);
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        dz_shadow = cfg_ch.turn_deadzone;
        n_cfg++;
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        want = mix_wheels(make_cmd(in_ch.mode, in_ch.heading, in_ch.speed, in_ch.turn_stick),
                          dz_shadow);
        if (want.boosted) n_boost++;
        wheels_due.push_back(want);
        n_cmds++;
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (wheels_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: %0d %0d %0d",
                                    out_ch.right_drive, out_ch.left_drive, out_ch.tail_drive));
        end else begin
          want = wheels_due.pop_front();
          check_field("right_drive", out_ch.right_drive, want.right);
          check_field("left_drive", out_ch.left_drive, want.left);
          check_field("tail_drive", out_ch.tail_drive, want.tail);
        end
        n_results++;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, wheels_due.size());
      $display("FAIL kiwi_drive_motor_mixer_unit");
      $finish;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        stall_left = pick_stall() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(drive_cmd_t cmd);
    int gap;
    gap = (tx_idling && $urandom_range(0, 3) == 0) ? pick_stall() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= cmd.mode;
    in_ch.heading    <= cmd.heading;
    in_ch.speed      <= cmd.speed;
    in_ch.turn_stick <= cmd.turn_stick;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drop valid at the edge that took the last request of a burst
  task automatic go_quiet();
    in_ch.valid <= 1'b0;
  endtask

  // sample the queue away from the rising edge so the monitor has run, then
  // realign to a rising edge for driving
  task automatic wait_drained();
    @(negedge clk);
    while (wheels_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_deadzone(int value);
    wait_drained();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.turn_deadzone <= 7'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed_corners();
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 0, 127, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 1024, 127, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 2048, 127, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 3072, 127, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 4095, -128, -128));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 0, 0, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 300, 0, 127));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 300, 0, -128));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 1024, 127, 9));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 1024, 127, 10));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 3072, -127, -10));
    send_cmd(make_cmd(kdm_pkg::MODE_LEFT, 777, 5, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_RIGHT, 3000, -50, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_BOTH, 100, -128, 40));
    send_cmd(make_cmd(kdm_pkg::MODE_LEFT, 4095, 127, -127));
    send_cmd(make_cmd(kdm_pkg::MODE_RIGHT, 0, 0, -128));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 1365, -128, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 1138, 127, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 2731, -127, 0));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 512, 64, 64));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 3583, -127, -127));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 2560, 85, 42));
    go_quiet();
  endtask

  task automatic test_deadzone_limits();
    write_deadzone(0);
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 0, 0, 1));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 0, 0, -1));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 1024, 100, 3));
    go_quiet();
    write_deadzone(127);
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 1024, 127, -127));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 1024, 127, 127));
    send_cmd(make_cmd(kdm_pkg::MODE_JOY, 3072, 0, -128));
    send_cmd(make_cmd(kdm_pkg::MODE_RIGHT, 0, 0, 126));
    send_cmd(make_cmd(kdm_pkg::MODE_LEFT, 0, 0, -126));
    go_quiet();
  endtask

  task automatic test_random_traffic();
    int dz_plan [7] = '{10, 0, 127, -1, 1, -1, -1};
    int dz;
    for (int k = 0; k < 7; k++) begin
      dz = (dz_plan[k] < 0) ? $urandom_range(0, 127) : dz_plan[k];
      write_deadzone(dz);
      // first setting runs back to back; one lets only the sender idle
      tx_idling = (k != 0);
      rx_idling = (k != 0) && (k != 3);
      for (int i = 0; i < 100; i++) send_cmd(random_cmd());
      go_quiet();
    end
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    hold_requests++;
    for (int i = 0; i < 60; i++) send_cmd(random_cmd());
    go_quiet();
  endtask

  initial begin
    for (int f = 0; f <= QUARTER; f++) cos_lut[f] = taylor_cos_q14(f);
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.mode           <= kdm_pkg::MODE_JOY;
    in_ch.heading        <= '0;
    in_ch.speed          <= '0;
    in_ch.turn_stick     <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.turn_deadzone <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_deadzone_limits();
    test_random_traffic();
    test_output_backpressure();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Mixed %0d drive commands into %0d checked wheel sets, %0d with side-wheel boost,",
             n_cmds, n_results, n_boost);
    $display("over %0d deadzone writes, random idling and a %0d-cycle output hold-off.",
             n_cfg, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS kiwi_drive_motor_mixer_unit");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL kiwi_drive_motor_mixer_unit");
    end
    $finish;
  end

endmodule
